### hw/rtl/cst_pkg.sv
// Shared types and constants for the clock / stopwatch / timer core.
// Operation and mode codes, field widths, limits and reset values.
// No dependencies.
package cst_pkg;

    localparam int unsigned OP_W   = 3;
    localparam int unsigned HOUR_W = 5;
    localparam int unsigned MIN_W  = 6;
    localparam int unsigned SEC_W  = 6;
    localparam int unsigned MODE_W = 2;

    localparam logic [OP_W-1:0] OP_TICK      = 3'd0;
    localparam logic [OP_W-1:0] OP_PAUSE     = 3'd1;
    localparam logic [OP_W-1:0] OP_RESUME    = 3'd2;
    localparam logic [OP_W-1:0] OP_SET       = 3'd3;
    localparam logic [OP_W-1:0] OP_STOPWATCH = 3'd4;
    localparam logic [OP_W-1:0] OP_TIMER     = 3'd5;
    localparam logic [OP_W-1:0] OP_EXIT      = 3'd6;

    localparam logic [MODE_W-1:0] MODE_CLOCK     = 2'd0;
    localparam logic [MODE_W-1:0] MODE_STOPWATCH = 2'd1;
    localparam logic [MODE_W-1:0] MODE_TIMER     = 2'd2;

    localparam logic [HOUR_W-1:0] MAX_HOUR = 5'd23;
    localparam logic [MIN_W-1:0]  MAX_MIN  = 6'd59;
    localparam logic [SEC_W-1:0]  MAX_SEC  = 6'd59;

    localparam logic [HOUR_W-1:0] RST_HOUR = 5'd13;
    localparam logic [MIN_W-1:0]  RST_MIN  = 6'd9;
    localparam logic [SEC_W-1:0]  RST_SEC  = 6'd57;

    typedef struct packed {
        logic [OP_W-1:0]   op;
        logic [HOUR_W-1:0] hours;
        logic [MIN_W-1:0]  minutes;
        logic [SEC_W-1:0]  seconds;
    } t_item;

    typedef struct packed {
        logic [HOUR_W-1:0] hours;
        logic [MIN_W-1:0]  minutes;
        logic [SEC_W-1:0]  seconds;
        logic [MODE_W-1:0] mode;
        logic              running;
        logic              done;
        logic              status;
    } t_result;

endpackage

### hw/rtl/clock_stopwatch_timer_core.sv
// Clock / stopwatch / countdown timer core, top level.
// Input register, next-state engine and result register in one pipe.
// Depends on cst_pkg, cst_in_stage, cst_engine, cst_out_stage.
//
// Input channel: i_in_valid / o_in_stall with operation and set values.
// An operation is a one-second tick or a command (pause, resume, set,
// stopwatch, timer, exit). Each transaction yields exactly one result on
// o_out_valid / i_out_stall: the count, mode and run flag after the item,
// plus a done flag for a finished countdown and a reject status for bad
// set values.
// An accepted item is held in the input register and its result then in the
// result register; one item per cycle is sustained while the receiver does not stall.
// Reset (synchronous, active low) empties both registers and loads the
// count 13:09:57 in clock mode, running, with the saved time cleared.
// When the receiver stalls the result holds; the input register still
// fills, and o_in_stall rises only once both stages hold an item.
module clock_stopwatch_timer_core (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_in_valid,
    output logic                       o_in_stall,
    input  logic [cst_pkg::OP_W-1:0]   i_operation,
    input  logic [cst_pkg::HOUR_W-1:0] i_new_hours,
    input  logic [cst_pkg::MIN_W-1:0]  i_new_minutes,
    input  logic [cst_pkg::SEC_W-1:0]  i_new_seconds,
    output logic                       o_out_valid,
    input  logic                       i_out_stall,
    output logic [cst_pkg::HOUR_W-1:0] o_hours_now,
    output logic [cst_pkg::MIN_W-1:0]  o_minutes_now,
    output logic [cst_pkg::SEC_W-1:0]  o_seconds_now,
    output logic [cst_pkg::MODE_W-1:0] o_mode_now,
    output logic                       o_is_running,
    output logic                       o_timer_done,
    output logic                       o_status
);

    cst_pkg::t_item   in_item;
    cst_pkg::t_item   reg_item;
    cst_pkg::t_result next_result;
    cst_pkg::t_result out_result;
    logic             reg_valid;
    logic             out_blocked;
    logic             fire;

    assign in_item.op      = i_operation;
    assign in_item.hours   = i_new_hours;
    assign in_item.minutes = i_new_minutes;
    assign in_item.seconds = i_new_seconds;

    assign out_blocked = o_out_valid && i_out_stall;
    assign fire        = reg_valid && !out_blocked;
    assign o_in_stall  = reg_valid && out_blocked;

    cst_in_stage u_in (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_in_valid),
        .i_stall (o_in_stall),
        .i_item  (in_item),
        .o_valid (reg_valid),
        .o_item  (reg_item)
    );

    cst_engine u_engine (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_fire   (fire),
        .i_item   (reg_item),
        .o_result (next_result)
    );

    cst_out_stage u_out (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_fire   (fire),
        .i_stall  (i_out_stall),
        .i_result (next_result),
        .o_valid  (o_out_valid),
        .o_result (out_result)
    );

    assign o_hours_now   = out_result.hours;
    assign o_minutes_now = out_result.minutes;
    assign o_seconds_now = out_result.seconds;
    assign o_mode_now    = out_result.mode;
    assign o_is_running  = out_result.running;
    assign o_timer_done  = out_result.done;
    assign o_status      = out_result.status;

    a_done_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_timer_done |-> o_mode_now == cst_pkg::MODE_CLOCK && !o_is_running
            && o_hours_now == '0 && o_minutes_now == '0 && o_seconds_now == '0)
        else $error("finished countdown not left at zero in paused clock mode");

    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_hours_now <= cst_pkg::MAX_HOUR && o_minutes_now <= cst_pkg::MAX_MIN
            && o_seconds_now <= cst_pkg::MAX_SEC)
        else $error("count out of range");

    a_status_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_status |-> !o_timer_done)
        else $error("reject status together with countdown done");

    a_stall_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> reg_valid && o_out_valid)
        else $error("input stalled with an empty stage");

endmodule

### hw/rtl/cst_in_stage.sv
// Input register of the clock / stopwatch / timer core.
// Captures one transaction whenever it is not holding back the sender.
// Depends on cst_pkg.
module cst_in_stage (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    input  logic           i_stall,
    input  cst_pkg::t_item i_item,
    output logic           o_valid,
    output cst_pkg::t_item o_item
);

    logic           r_valid;
    cst_pkg::t_item r_item;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (!i_stall) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_stall) begin
            r_item <= i_item;
        end
    end

    assign o_valid = r_valid;
    assign o_item  = r_item;

endmodule

### hw/rtl/cst_engine.sv
// Time-keeping state and its next-state logic.
// Holds count, saved time, mode and run flag; updates on each fired item.
// Depends on cst_pkg.
module cst_engine (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_fire,
    input  cst_pkg::t_item   i_item,
    output cst_pkg::t_result o_result
);

    logic [cst_pkg::HOUR_W-1:0] r_hours, n_hours;
    logic [cst_pkg::MIN_W-1:0]  r_minutes, n_minutes;
    logic [cst_pkg::SEC_W-1:0]  r_seconds, n_seconds;
    logic [cst_pkg::HOUR_W-1:0] r_sv_hours, n_sv_hours;
    logic [cst_pkg::MIN_W-1:0]  r_sv_minutes, n_sv_minutes;
    logic [cst_pkg::SEC_W-1:0]  r_sv_seconds, n_sv_seconds;
    logic [cst_pkg::MODE_W-1:0] r_mode, n_mode;
    logic                       r_running, n_running;
    logic                       done;
    logic                       status;

    always_comb begin
        logic                       in_range;
        logic [cst_pkg::SEC_W:0]    up_s;
        logic [cst_pkg::MIN_W:0]    up_m;
        logic [cst_pkg::HOUR_W:0]   up_h;
        logic [cst_pkg::SEC_W-1:0]  dn_s;
        logic [cst_pkg::MIN_W-1:0]  dn_m;
        logic [cst_pkg::HOUR_W-1:0] dn_h;
        logic                       brw_m;
        logic                       brw_h;

        in_range = (i_item.hours <= cst_pkg::MAX_HOUR) && (i_item.minutes <= cst_pkg::MAX_MIN)
                   && (i_item.seconds <= cst_pkg::MAX_SEC);

        up_s = {1'b0, r_seconds} + 7'd1;
        up_m = {1'b0, r_minutes};
        up_h = {1'b0, r_hours};
        if (up_s > {1'b0, cst_pkg::MAX_SEC}) begin
            up_s = '0;
            up_m = up_m + 7'd1;
        end
        if (up_m > {1'b0, cst_pkg::MAX_MIN}) begin
            up_m = '0;
            up_h = up_h + 6'd1;
        end
        if (up_h > {1'b0, cst_pkg::MAX_HOUR}) begin
            up_h = '0;
        end

        brw_m = (r_seconds == '0);
        dn_s  = brw_m ? cst_pkg::MAX_SEC : r_seconds - 6'd1;
        brw_h = brw_m && (r_minutes == '0);
        dn_m  = r_minutes;
        if (brw_m) begin
            dn_m = brw_h ? cst_pkg::MAX_MIN : r_minutes - 6'd1;
        end
        dn_h = (brw_h && r_hours != '0) ? r_hours - 5'd1 : r_hours;

        n_hours      = r_hours;
        n_minutes    = r_minutes;
        n_seconds    = r_seconds;
        n_sv_hours   = r_sv_hours;
        n_sv_minutes = r_sv_minutes;
        n_sv_seconds = r_sv_seconds;
        n_mode       = r_mode;
        n_running    = r_running;
        done         = 1'b0;
        status       = 1'b0;

        unique case (i_item.op)
            cst_pkg::OP_TICK: begin
                if (r_running) begin
                    if (r_mode != cst_pkg::MODE_TIMER) begin
                        n_hours   = up_h[cst_pkg::HOUR_W-1:0];
                        n_minutes = up_m[cst_pkg::MIN_W-1:0];
                        n_seconds = up_s[cst_pkg::SEC_W-1:0];
                    end else begin
                        n_hours   = dn_h;
                        n_minutes = dn_m;
                        n_seconds = dn_s;
                        if (dn_h == '0 && dn_m == '0 && dn_s == '0) begin
                            n_mode    = cst_pkg::MODE_CLOCK;
                            n_running = 1'b0;
                            done      = 1'b1;
                        end
                    end
                end
            end
            cst_pkg::OP_PAUSE: begin
                n_running = 1'b0;
            end
            cst_pkg::OP_RESUME: begin
                n_running = 1'b1;
            end
            cst_pkg::OP_SET: begin
                if (in_range) begin
                    n_hours   = i_item.hours;
                    n_minutes = i_item.minutes;
                    n_seconds = i_item.seconds;
                end else begin
                    status = 1'b1;
                end
            end
            cst_pkg::OP_STOPWATCH: begin
                n_sv_hours   = r_hours;
                n_sv_minutes = r_minutes;
                n_sv_seconds = r_seconds;
                n_hours      = '0;
                n_minutes    = '0;
                n_seconds    = '0;
                n_mode       = cst_pkg::MODE_STOPWATCH;
                n_running    = 1'b0;
            end
            cst_pkg::OP_TIMER: begin
                if (in_range) begin
                    n_sv_hours   = r_hours;
                    n_sv_minutes = r_minutes;
                    n_sv_seconds = r_seconds;
                    n_hours      = i_item.hours;
                    n_minutes    = i_item.minutes;
                    n_seconds    = i_item.seconds;
                    n_mode       = cst_pkg::MODE_TIMER;
                    n_running    = 1'b0;
                end else begin
                    status = 1'b1;
                end
            end
            cst_pkg::OP_EXIT: begin
                n_hours      = r_sv_hours;
                n_minutes    = r_sv_minutes;
                n_seconds    = r_sv_seconds;
                n_sv_hours   = '0;
                n_sv_minutes = '0;
                n_sv_seconds = '0;
                n_mode       = cst_pkg::MODE_CLOCK;
                n_running    = 1'b1;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hours      <= cst_pkg::RST_HOUR;
            r_minutes    <= cst_pkg::RST_MIN;
            r_seconds    <= cst_pkg::RST_SEC;
            r_sv_hours   <= '0;
            r_sv_minutes <= '0;
            r_sv_seconds <= '0;
            r_mode       <= cst_pkg::MODE_CLOCK;
            r_running    <= 1'b1;
        end else if (i_fire) begin
            r_hours      <= n_hours;
            r_minutes    <= n_minutes;
            r_seconds    <= n_seconds;
            r_sv_hours   <= n_sv_hours;
            r_sv_minutes <= n_sv_minutes;
            r_sv_seconds <= n_sv_seconds;
            r_mode       <= n_mode;
            r_running    <= n_running;
        end
    end

    always_comb begin
        o_result.hours   = n_hours;
        o_result.minutes = n_minutes;
        o_result.seconds = n_seconds;
        o_result.mode    = n_mode;
        o_result.running = n_running;
        o_result.done    = done;
        o_result.status  = status;
    end

endmodule

### hw/rtl/cst_out_stage.sv
// Result register of the clock / stopwatch / timer core.
// Loads on each fired item, holds while the receiver stalls.
// Depends on cst_pkg.
module cst_out_stage (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_fire,
    input  logic             i_stall,
    input  cst_pkg::t_result i_result,
    output logic             o_valid,
    output cst_pkg::t_result o_result
);

    logic             r_valid;
    cst_pkg::t_result r_result;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_fire) begin
            r_valid <= 1'b1;
        end else if (!i_stall) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_fire) begin
            r_result <= i_result;
        end
    end

    assign o_valid  = r_valid;
    assign o_result = r_result;

endmodule
